[src/xcorr_pkg.sv]
// Shared widths, codes and the product rounding function of the cross-correlator.
package xcorr_pkg;

  // Field widths
  localparam int SAMPLE_W = 32;
  localparam int OPCODE_W = 2;
  localparam int FRAC_W   = 5;
  localparam int LAG_W    = 6;
  localparam int STATUS_W = 2;

  // Default store depth
  localparam int MAX_LEN_DEF = 32;

  // Register reset value
  localparam logic [FRAC_W-1:0] FRAC_RESET = 5'd31;

  // Command codes
  localparam logic [OPCODE_W-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RUN    = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd2;

  // Round a product: shift right by frac_bits-1 (by zero when frac_bits is zero), add one, shift right by one.
  function automatic logic [SAMPLE_W-1:0] round_product(
    input logic [SAMPLE_W-1:0] prod,
    input logic [FRAC_W-1:0]   frac_bits
  );
    logic [FRAC_W-1:0]   sh;
    logic [SAMPLE_W-1:0] t;
    sh = (frac_bits == '0) ? '0 : frac_bits - FRAC_W'(1);
    t  = SAMPLE_W'($signed(prod) >>> sh) + SAMPLE_W'(1);
    return SAMPLE_W'($signed(t) >>> 1);
  endfunction

endpackage

[src/xcorr_ifs.sv]
// Valid/ready channel interfaces for commands and correlation results.
interface xcorr_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic [xcorr_pkg::OPCODE_W-1:0]       opcode;
  logic signed [xcorr_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output opcode, output sample, input ready);
  modport sink   (input valid, input opcode, input sample, output ready);
endinterface

interface xcorr_res_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [xcorr_pkg::SAMPLE_W-1:0] corr_value;
  logic [xcorr_pkg::LAG_W-1:0]          lag_index;
  logic                                 last_flag;
  logic [xcorr_pkg::STATUS_W-1:0]       status;

  modport source (output valid, output corr_value, output lag_index, output last_flag,
                  output status, input ready);
  modport sink   (input valid, input corr_value, input lag_index, input last_flag,
                  input status, output ready);
endinterface

[src/xcorr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module xcorr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/fixed_point_cross_correlation.sv]
// Top level of the fixed-point full cross-correlator.
//
// Loads (opcode 0 into A, opcode 1 into B) produce no result; a load into a
// full store is dropped and the next run reports status 2. A run (opcode 2)
// computes Na+Nb-1 lags with one shared 32x32 multiplier and one accumulator
// under a small sequencer: each product passes through a store read, a multiply
// and a round-and-accumulate state, and each lag adds a setup state and the
// result transfer; a stalled result channel holds the sequencer. The command
// channel is not ready during a run. A run with an empty vector returns a
// single status 1 result. frac_bits is written through cfg_we/cfg_wdata and
// resets to 31; the user must write it only while the block is idle (unchecked).
module fixed_point_cross_correlation #(
  parameter int MAX_LEN = xcorr_pkg::MAX_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [xcorr_pkg::FRAC_W-1:0] cfg_wdata,
  xcorr_cmd_if.sink                    cmd,
  xcorr_res_if.source                  result
);

  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int SW     = xcorr_pkg::SAMPLE_W;
  localparam int LW     = xcorr_pkg::LAG_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_READ,
    S_MUL,
    S_ACC,
    S_OUT
  } state_t;

  state_t                     state;
  logic [xcorr_pkg::FRAC_W-1:0] frac_bits;
  logic [CNT_W-1:0]           count_a;
  logic [CNT_W-1:0]           count_b;
  logic                       dropped_flag;
  logic [CNT_W-1:0]           run_na;
  logic [CNT_W-1:0]           run_nb;
  logic [xcorr_pkg::STATUS_W-1:0] run_status;
  logic [LW-1:0]              lag;
  logic [LW-1:0]              last_lag;
  logic [ADDR_W-1:0]          k;
  logic [ADDR_W-1:0]          k_end;
  logic [ADDR_W-1:0]          b_idx;
  logic [SW-1:0]              prod;
  logic [SW-1:0]              acc;
  logic [SW-1:0]              res_value;
  logic [LW-1:0]              res_lag;
  logic                       res_last;
  logic [xcorr_pkg::STATUS_W-1:0] res_status;

  logic          cmd_xfer;
  logic          res_xfer;
  logic          we_a;
  logic          we_b;
  logic [SW-1:0] rd_a;
  logic [SW-1:0] rd_b;
  logic [LW:0]   lag_plus;
  logic [LW:0]   nb_ext;
  logic [LW:0]   na_ext;
  logic [SW-1:0] acc_next;

  assign cmd_xfer = cmd.valid && cmd.ready;
  assign res_xfer = result.valid && result.ready;
  assign cmd.ready    = (state == S_IDLE);
  assign result.valid = (state == S_OUT);

  assign result.corr_value = $signed(res_value);
  assign result.lag_index  = res_lag;
  assign result.last_flag  = res_last;
  assign result.status     = res_status;

  // Store writes on accepted loads that still fit
  assign we_a = cmd_xfer && (cmd.opcode == xcorr_pkg::OP_LOAD_A) &&
                (count_a < CNT_W'(MAX_LEN));
  assign we_b = cmd_xfer && (cmd.opcode == xcorr_pkg::OP_LOAD_B) &&
                (count_b < CNT_W'(MAX_LEN));

  xcorr_ram #(.WIDTH(SW), .DEPTH(MAX_LEN)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (count_a[ADDR_W-1:0]),
    .wdata (cmd.sample),
    .raddr (k),
    .rdata (rd_a)
  );

  xcorr_ram #(.WIDTH(SW), .DEPTH(MAX_LEN)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (count_b[ADDR_W-1:0]),
    .wdata (cmd.sample),
    .raddr (b_idx),
    .rdata (rd_b)
  );

  // Lag window bounds
  assign lag_plus = {1'b0, lag} + (LW + 1)'(1);
  assign nb_ext   = (LW + 1)'(run_nb);
  assign na_ext   = (LW + 1)'(run_na);
  assign acc_next = acc + xcorr_pkg::round_product(prod, frac_bits);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      frac_bits <= xcorr_pkg::FRAC_RESET;
    end else if (cfg_we) begin
      frac_bits <= cfg_wdata;
    end
  end

  // Sequencer, counts and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count_a      <= '0;
      count_b      <= '0;
      dropped_flag <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_xfer) begin
            case (cmd.opcode)
              xcorr_pkg::OP_LOAD_A: begin
                if (we_a) count_a <= count_a + CNT_W'(1);
                else dropped_flag <= 1'b1;
              end
              xcorr_pkg::OP_LOAD_B: begin
                if (we_b) count_b <= count_b + CNT_W'(1);
                else dropped_flag <= 1'b1;
              end
              xcorr_pkg::OP_RUN: begin
                count_a      <= '0;
                count_b      <= '0;
                dropped_flag <= 1'b0;
                run_na       <= count_a;
                run_nb       <= count_b;
                run_status   <= dropped_flag ? xcorr_pkg::ST_DROPPED : xcorr_pkg::ST_OK;
                lag          <= '0;
                last_lag     <= LW'((CNT_W + 1)'(count_a) + (CNT_W + 1)'(count_b) -
                                    (CNT_W + 1)'(2));
                if (count_a == '0 || count_b == '0) begin
                  res_value  <= '0;
                  res_lag    <= '0;
                  res_last   <= 1'b1;
                  res_status <= xcorr_pkg::ST_EMPTY;
                  state      <= S_OUT;
                end else begin
                  state <= S_SETUP;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SETUP: begin
          // first term of this lag and the last A index it uses
          acc <= '0;
          if (lag_plus >= nb_ext) begin
            k     <= ADDR_W'(lag_plus - nb_ext);
            b_idx <= '0;
          end else begin
            k     <= '0;
            b_idx <= ADDR_W'(nb_ext - lag_plus);
          end
          if ({1'b0, lag} < na_ext) k_end <= lag[ADDR_W-1:0];
          else k_end <= ADDR_W'(run_na - CNT_W'(1));
          state <= S_READ;
        end
        S_READ: begin
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= rd_a * rd_b;
          state <= S_ACC;
        end
        S_ACC: begin
          if (k == k_end) begin
            res_value  <= acc_next;
            res_lag    <= lag;
            res_last   <= (lag == last_lag);
            res_status <= run_status;
            state      <= S_OUT;
          end else begin
            acc   <= acc_next;
            k     <= k + ADDR_W'(1);
            b_idx <= b_idx + ADDR_W'(1);
            state <= S_READ;
          end
        end
        S_OUT: begin
          if (res_xfer) begin
            if (res_last) begin
              state <= S_IDLE;
            end else begin
              lag   <= lag + LW'(1);
              state <= S_SETUP;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
